@@ hdl/mfde_pkg.sv @@
// ----------------------------------------------------------------------------
// mfde_pkg
// Shared types, constants and the 5x7 glyph table of the frame buffer engine.
// ----------------------------------------------------------------------------
package mfde_pkg;

  localparam int SCREEN_WIDTH = 128;
  localparam int COL_W        = 7;

  // request codes
  typedef enum logic [2:0] {
    OP_PIXEL = 3'd0,
    OP_GLYPH = 3'd1,
    OP_CLEAR = 3'd2,
    OP_BAR   = 3'd3,
    OP_READ  = 3'd4
  } mfde_op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_MOD_RD,
    ST_MOD_WR,
    ST_READ,
    ST_RDATA
  } mfde_state_e;

  // glyph table
  localparam int         GLYPH_COUNT = 59;
  localparam logic [7:0] GLYPH_FIRST = 8'd32;
  localparam logic [7:0] GLYPH_LAST  = 8'd90;
  localparam logic [COL_W-1:0] GLYPH_LAST_COL = 7'd4;

  // progress bar
  localparam logic [COL_W-1:0] COL_LAST  = 7'd127;
  localparam logic [6:0]       PCT_FULL  = 7'd100;
  localparam logic [13:0]      BAR_SPAN  = 14'(SCREEN_WIDTH - 4);
  localparam logic [4:0]       BAR_PAGE_HI = 5'd2;   // rows 16..23
  localparam logic [4:0]       BAR_PAGE_LO = 5'd3;   // rows 24..31
  localparam logic [7:0]       BAR_HI_EDGE = 8'hF0;
  localparam logic [7:0]       BAR_HI_FILL = 8'hD0;
  localparam logic [7:0]       BAR_HI_LINE = 8'h10;
  localparam logic [7:0]       BAR_LO_EDGE = 8'hFF;
  localparam logic [7:0]       BAR_LO_FILL = 8'hBF;
  localparam logic [7:0]       BAR_LO_LINE = 8'h80;

  // decoded command, front to back
  typedef struct packed {
    mfde_op_e    op;
    logic [7:0]  x_pos;
    logic [7:0]  y_pos;
    logic        pixel_on;
    logic [5:0]  glyph;
    logic [13:0] fill_num;   // min(percent,100) * (width - 4)
    logic [8:0]  byte_index;
  } mfde_cmd_t;

  // back status toward the front
  typedef struct packed {
    logic ready;
    logic init;
  } mfde_bstat_t;

  // column 0 in bits 39:32, column 4 in bits 7:0
  localparam logic [39:0] GLYPH_ROM [GLYPH_COUNT] = '{
    40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14,
    40'h242A7F2A12, 40'h2313086462, 40'h3649552250, 40'h0005030000,
    40'h001C224100, 40'h0041221C00, 40'h14083E0814, 40'h08083E0808,
    40'h0050300000, 40'h0808080808, 40'h0060600000, 40'h2010080402,
    40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
    40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503,
    40'h3649494936, 40'h064949291E, 40'h0036360000, 40'h0056360000,
    40'h0814224100, 40'h1414141414, 40'h0041221408, 40'h0201510906,
    40'h324979413E, 40'h7E1111117E, 40'h7F49494936, 40'h3E41414122,
    40'h7F4141221C, 40'h7F49494941, 40'h7F09090901, 40'h3E4149497A,
    40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241,
    40'h7F40404040, 40'h7F020C027F, 40'h7F0408107F, 40'h3E4141413E,
    40'h7F09090906, 40'h3E4151215E, 40'h7F09192946, 40'h4649494931,
    40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F, 40'h3F4038403F,
    40'h6314081463, 40'h0708700807, 40'h6151494543
  };

endpackage

@@ hdl/mfde_ram.sv @@
// ----------------------------------------------------------------------------
// mfde_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mfde_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/mfde_front.sv @@
// ----------------------------------------------------------------------------
// mfde_front
// Accepts requests, drops unknown codes, decodes glyph and bar fields and
// holds up to two commands for the back end.
// ----------------------------------------------------------------------------
module mfde_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  output logic                  full_o,
  input  logic [2:0]            req_type_i,
  input  logic [7:0]            x_pos_i,
  input  logic [7:0]            y_pos_i,
  input  logic                  pixel_on_i,
  input  logic [7:0]            char_code_i,
  input  logic [7:0]            percent_i,
  input  logic [8:0]            byte_index_i,
  output mfde_pkg::mfde_cmd_t   cmd_o,
  output logic                  cmd_valid_o,
  input  mfde_pkg::mfde_bstat_t bstat_i
);
  import mfde_pkg::*;

  mfde_cmd_t  fifo_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;

  mfde_cmd_t  dec;
  logic       known;
  logic [6:0] pct_sat;
  logic       accept, enq, deq;

  always_comb begin
    unique case (req_type_i)
      OP_PIXEL, OP_GLYPH, OP_CLEAR, OP_BAR, OP_READ: known = 1'b1;
      default:                                      known = 1'b0;
    endcase
  end

  always_comb begin
    pct_sat        = (percent_i > 8'(PCT_FULL)) ? PCT_FULL : percent_i[6:0];
    dec.op         = mfde_op_e'(req_type_i);
    dec.x_pos      = x_pos_i;
    dec.y_pos      = y_pos_i;
    dec.pixel_on   = pixel_on_i;
    // codes outside the table draw a space
    dec.glyph      = (char_code_i >= GLYPH_FIRST && char_code_i <= GLYPH_LAST) ?
                     6'(char_code_i - GLYPH_FIRST) : 6'd0;
    dec.fill_num   = 14'(pct_sat) * BAR_SPAN;
    dec.byte_index = byte_index_i;
  end

  assign full_o      = (cnt_q == 2'd2) || bstat_i.init;
  assign accept      = push_i && !full_o;
  assign enq         = accept && known;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign deq         = cmd_valid_o && bstat_i.ready;
  assign cmd_o       = fifo_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (enq) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (deq) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      cnt_q <= cnt_q + 2'(enq) - 2'(deq);
    end
  end

  always_ff @(posedge clk_i) begin
    if (enq) begin
      fifo_q[wr_ptr_q] <= dec;
    end
  end

endmodule

@@ hdl/mfde_back.sv @@
// ----------------------------------------------------------------------------
// mfde_back
// Executes commands as byte read-modify-writes on the frame store, runs the
// clear sweep and queues read-back bytes for the result side.
// ----------------------------------------------------------------------------
module mfde_back #(
  parameter int SCREEN_HEIGHT = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  mfde_pkg::mfde_cmd_t   cmd_i,
  input  logic                  cmd_valid_i,
  output mfde_pkg::mfde_bstat_t bstat_o,
  output logic                  empty_o,
  input  logic                  pop_i,
  output logic [7:0]            read_data_o
);
  import mfde_pkg::*;

  localparam int STORE_BYTES = SCREEN_WIDTH * SCREEN_HEIGHT / 8;
  localparam int ADDR_W      = $clog2(STORE_BYTES);
  localparam logic [4:0]        PAGES     = 5'((SCREEN_HEIGHT + 7) / 8);
  localparam logic [4:0]        FULL_PG   = 5'(SCREEN_HEIGHT / 8);
  localparam logic [7:0]        PART_ROWS = 8'((1 << (SCREEN_HEIGHT % 8)) - 1);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(STORE_BYTES - 1);

  mfde_state_e       state_q, state_d;
  mfde_cmd_t         cmd_q, cmd_d;
  logic [COL_W-1:0]  col_q, col_d;
  logic              half_q, half_d;
  logic [39:0]       glyph_q, glyph_d;
  logic [ADDR_W-1:0] clr_q, clr_d;
  logic              init_q, init_d;

  // step decode
  logic [4:0]        page;
  logic [7:0]        col_x;
  logic [7:0]        mask;
  logic [7:0]        row_ok;
  logic              in_store;
  logic [15:0]       shifted;
  logic [13:0]       fill_lhs;
  logic              fill;
  logic [7:0]        step_set, step_clr;
  logic              step_ok, step_last;
  logic [ADDR_W-1:0] step_addr;

  // ram
  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [7:0]        ram_wdata, ram_rdata;

  // result queue
  logic [7:0]        out_q [2];
  logic              out_wr_q, out_rd_q;
  logic [1:0]        out_cnt_q;
  logic              out_push, out_pop, out_full;
  logic [7:0]        out_data;
  logic              take_ok;
  logic              idx_ok;

  mfde_ram #(
    .WIDTH (8),
    .DEPTH (STORE_BYTES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign fill_lhs = (14'(col_q) - 14'd1) * 14'(PCT_FULL);
  assign fill     = (col_q >= 7'd2) && (fill_lhs <= cmd_q.fill_num);
  assign shifted  = {8'h00, glyph_q[39:32]} << cmd_q.y_pos[2:0];
  assign idx_ok   = {23'd0, cmd_q.byte_index} < 32'(STORE_BYTES);

  // one byte of the current command
  always_comb begin
    page      = 5'd0;
    col_x     = 8'd0;
    mask      = 8'd0;
    step_set  = 8'd0;
    step_clr  = 8'd0;
    step_ok   = 1'b0;
    step_last = 1'b1;
    unique case (cmd_q.op)
      OP_PIXEL: begin
        col_x    = cmd_q.x_pos;
        page     = cmd_q.y_pos[7:3];
        mask     = 8'b1 << cmd_q.y_pos[2:0];
        step_set = cmd_q.pixel_on ? mask : 8'd0;
        step_clr = cmd_q.pixel_on ? 8'd0 : mask;
        step_ok  = !col_x[7] && (page < PAGES);
      end
      OP_GLYPH: begin
        // wraps at 8 bits in both directions
        col_x     = cmd_q.x_pos + 8'(col_q);
        page      = cmd_q.y_pos[7:3] + 5'(half_q);
        mask      = half_q ? shifted[15:8] : shifted[7:0];
        step_set  = mask;
        step_ok   = !col_x[7] && (page < PAGES) && (mask != 8'd0);
        step_last = (col_q == GLYPH_LAST_COL) && half_q;
      end
      OP_BAR: begin
        col_x = {1'b0, col_q};
        page  = half_q ? BAR_PAGE_LO : BAR_PAGE_HI;
        if (col_q == 7'd0 || col_q == COL_LAST) begin
          mask = half_q ? BAR_LO_EDGE : BAR_HI_EDGE;
        end else if (fill) begin
          mask = half_q ? BAR_LO_FILL : BAR_HI_FILL;
        end else begin
          mask = half_q ? BAR_LO_LINE : BAR_HI_LINE;
        end
        step_set  = mask;
        step_ok   = (page < PAGES);
        step_last = (col_q == COL_LAST) && half_q;
      end
      default: begin
      end
    endcase
    // rows below the screen and bytes past the store end are dropped
    row_ok    = (page < FULL_PG) ? 8'hFF : ((page == FULL_PG) ? PART_ROWS : 8'h00);
    in_store  = 32'({page, col_x[COL_W-1:0]}) < 32'(STORE_BYTES);
    step_set  = step_set & row_ok;
    step_clr  = step_clr & row_ok;
    step_ok   = step_ok && in_store && ((mask & row_ok) != 8'd0);
    step_addr = ADDR_W'({page, col_x[COL_W-1:0]});
  end

  assign out_full = (out_cnt_q == 2'd2);
  assign take_ok  = !(cmd_i.op == OP_READ && out_full);

  always_comb begin
    state_d   = state_q;
    cmd_d     = cmd_q;
    col_d     = col_q;
    half_d    = half_q;
    glyph_d   = glyph_q;
    clr_d     = clr_q;
    init_d    = init_q;
    ram_we    = 1'b0;
    ram_waddr = step_addr;
    ram_wdata = 8'd0;
    ram_re    = 1'b0;
    ram_raddr = step_addr;
    out_push  = 1'b0;
    out_data  = 8'd0;
    bstat_o.ready = 1'b0;
    bstat_o.init  = init_q;
    unique case (state_q)
      ST_IDLE: begin
        bstat_o.ready = take_ok;
        if (cmd_valid_i && take_ok) begin
          cmd_d   = cmd_i;
          col_d   = '0;
          half_d  = 1'b0;
          glyph_d = GLYPH_ROM[cmd_i.glyph];
          clr_d   = '0;
          unique case (cmd_i.op)
            OP_CLEAR: state_d = ST_CLEAR;
            OP_READ:  state_d = ST_READ;
            default:  state_d = ST_MOD_RD;
          endcase
        end
      end
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        clr_d     = clr_q + ADDR_W'(1);
        if (clr_q == LAST_ADDR) begin
          state_d = ST_IDLE;
          init_d  = 1'b0;
        end
      end
      ST_MOD_RD: begin
        ram_re = step_ok;
        if (step_ok) begin
          state_d = ST_MOD_WR;
        end else if (step_last) begin
          state_d = ST_IDLE;
        end else begin
          col_d   = half_q ? col_q + COL_W'(1) : col_q;
          half_d  = !half_q;
          glyph_d = half_q ? (glyph_q << 8) : glyph_q;
        end
      end
      ST_MOD_WR: begin
        ram_we    = 1'b1;
        ram_wdata = (ram_rdata & ~step_clr) | step_set;
        if (step_last) begin
          state_d = ST_IDLE;
        end else begin
          state_d = ST_MOD_RD;
          col_d   = half_q ? col_q + COL_W'(1) : col_q;
          half_d  = !half_q;
          glyph_d = half_q ? (glyph_q << 8) : glyph_q;
        end
      end
      ST_READ: begin
        ram_re    = 1'b1;
        ram_raddr = ADDR_W'(cmd_q.byte_index);
        state_d   = ST_RDATA;
      end
      ST_RDATA: begin
        out_push = 1'b1;
        out_data = idx_ok ? ram_rdata : 8'd0;
        state_d  = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
      init_q  <= 1'b1;
      col_q   <= '0;
      half_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      init_q  <= init_d;
      col_q   <= col_d;
      half_q  <= half_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q   <= cmd_d;
    glyph_q <= glyph_d;
  end

  // result queue: a read is only started with a free slot
  assign empty_o     = (out_cnt_q == 2'd0);
  assign out_pop     = pop_i && !empty_o;
  assign read_data_o = out_q[out_rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_wr_q  <= 1'b0;
      out_rd_q  <= 1'b0;
      out_cnt_q <= 2'd0;
    end else begin
      if (out_push) begin
        out_wr_q <= !out_wr_q;
      end
      if (out_pop) begin
        out_rd_q <= !out_rd_q;
      end
      out_cnt_q <= out_cnt_q + 2'(out_push) - 2'(out_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_push) begin
      out_q[out_wr_q] <= out_data;
    end
  end

endmodule

@@ hdl/mono_framebuffer_draw_engine_unit.sv @@
// ----------------------------------------------------------------------------
// mono_framebuffer_draw_engine_unit
// Page-organized 1-bit frame buffer with pixel, glyph, clear, bar and read.
// ----------------------------------------------------------------------------
// Requests enter through a queue-style port: a transfer happens when push is
// high and full is low. Only reads produce a result; it waits on read_data_o
// while empty is low and leaves on a transfer with pop high.
// The front holds up to two decoded commands, so requests keep flowing while
// the back works. The back picks up a command in its idle state, then does
// every pixel, glyph and bar change as a byte read-modify-write through the
// single-port-pair frame RAM; clear writes one byte per cycle.
// Off-screen and blank bytes of a glyph are skipped.
// With the back idle, a read's byte goes through ST_READ and ST_RDATA.
// After reset the store is swept to zero; full is held high until that sweep
// ends.
// A stalled receiver fills the two-entry result queue; the back then waits
// before starting another read, and the command queue absorbs new requests
// until it too is full.
// ----------------------------------------------------------------------------
module mono_framebuffer_draw_engine_unit #(
  parameter int SCREEN_HEIGHT = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [2:0] req_type_i,
  input  logic [7:0] x_pos_i,
  input  logic [7:0] y_pos_i,
  input  logic       pixel_on_i,
  input  logic [7:0] char_code_i,
  input  logic [7:0] percent_i,
  input  logic [8:0] byte_index_i,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] read_data_o
);
  import mfde_pkg::*;

  mfde_cmd_t   cmd;
  logic        cmd_valid;
  mfde_bstat_t bstat;

  mfde_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .full_o       (full),
    .req_type_i   (req_type_i),
    .x_pos_i      (x_pos_i),
    .y_pos_i      (y_pos_i),
    .pixel_on_i   (pixel_on_i),
    .char_code_i  (char_code_i),
    .percent_i    (percent_i),
    .byte_index_i (byte_index_i),
    .cmd_o        (cmd),
    .cmd_valid_o  (cmd_valid),
    .bstat_i      (bstat)
  );

  mfde_back #(
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .cmd_valid_i (cmd_valid),
    .bstat_o     (bstat),
    .empty_o     (empty),
    .pop_i       (pop),
    .read_data_o (read_data_o)
  );

  // nothing enters and nothing comes out during the reset sweep
  a_init_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bstat.init |-> (full && empty))
    else $error("traffic during reset sweep");

  a_sweep_after_reset: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> bstat.init)
    else $error("reset sweep not running after reset");

  a_cmd_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_valid && !bstat.ready) |=> cmd_valid)
    else $error("pending command lost between front and back");

endmodule
